// ===== rtl/core/cteu_pkg.sv =====
// ----------------------------------------------------------------------------
// cteu_pkg
// Shared types, codes and the month length table for the date/time editor.
// ----------------------------------------------------------------------------
package cteu_pkg;

  localparam logic [2:0] OP_LOAD    = 3'd0;
  localparam logic [2:0] OP_NEXT    = 3'd1;
  localparam logic [2:0] OP_INC     = 3'd2;
  localparam logic [2:0] OP_DEC     = 3'd3;
  localparam logic [2:0] OP_CONFIRM = 3'd4;
  localparam logic [2:0] OP_CANCEL  = 3'd5;

  localparam logic [2:0] SEL_YEAR   = 3'd0;
  localparam logic [2:0] SEL_MONTH  = 3'd1;
  localparam logic [2:0] SEL_DAY    = 3'd2;
  localparam logic [2:0] SEL_HOUR   = 3'd3;
  localparam logic [2:0] SEL_MINUTE = 3'd4;

  localparam logic [6:0] YEAR_MAX   = 7'd99;
  localparam logic [3:0] MONTH_MAX  = 4'd11;
  localparam logic [4:0] HOUR_MAX   = 5'd23;
  localparam logic [5:0] MINUTE_MAX = 6'd59;
  localparam logic [3:0] MONTH_FEB  = 4'd1;

  localparam logic [4:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef struct packed {
    logic [2:0] opcode;
    logic [6:0] load_year;
    logic [3:0] load_month;
    logic [4:0] load_day;
    logic [4:0] load_hour;
    logic [5:0] load_minute;
    logic       load_alarm;
  } req_t;

  typedef struct packed {
    logic [6:0] cur_year;
    logic [3:0] cur_month;
    logic [4:0] cur_day;
    logic [4:0] cur_hour;
    logic [5:0] cur_minute;
    logic [2:0] selected_field;
    logic       editing;
    logic       commit_strobe;
    logic       alarm_active;
  } rsp_t;

  typedef struct packed {
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [2:0] sel;
    logic       editing;
    logic       alarm;
  } state_t;

  function automatic logic [4:0] month_days(input logic [3:0] month, input logic [6:0] year);
    logic [3:0] m;
    logic [4:0] n;
    m = (month > MONTH_MAX) ? MONTH_MAX : month;
    n = MONTH_LEN[m];
    if (m == MONTH_FEB && year[1:0] == 2'b00) begin
      n = n + 5'd1;
    end
    return n;
  endfunction

endpackage

// ===== rtl/core/cteu_if.sv =====
// ----------------------------------------------------------------------------
// cteu_req_if / cteu_rsp_if
// Valid/ready channels carrying key events and editor results.
// ----------------------------------------------------------------------------
interface cteu_req_if import cteu_pkg::*;;
  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface cteu_rsp_if import cteu_pkg::*;;
  logic valid;
  logic ready;
  rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/cteu_step.sv =====
// ----------------------------------------------------------------------------
// cteu_step
// Next-state logic of the editor for one key event.
// ----------------------------------------------------------------------------
module cteu_step import cteu_pkg::*; (
  input  state_t     cur,
  input  req_t       item,
  output state_t     nxt,
  output logic       commit
);

  logic [4:0] n_days;
  logic [4:0] n_cur;

  assign n_cur = month_days(cur.month, cur.year);

  always_comb begin
    nxt = cur;
    commit = 1'b0;
    n_days = n_cur;
    if (item.opcode == OP_LOAD) begin
      nxt.year   = (item.load_year > YEAR_MAX) ? YEAR_MAX : item.load_year;
      nxt.month  = (item.load_month > MONTH_MAX) ? MONTH_MAX : item.load_month;
      nxt.hour   = (item.load_hour > HOUR_MAX) ? HOUR_MAX : item.load_hour;
      nxt.minute = (item.load_minute > MINUTE_MAX) ? MINUTE_MAX : item.load_minute;
      n_days = month_days(nxt.month, nxt.year);
      nxt.day = (item.load_day >= n_days) ? (n_days - 5'd1) : item.load_day;
      nxt.alarm = item.load_alarm;
      nxt.sel = SEL_HOUR;
      nxt.editing = 1'b1;
    end else if (cur.editing) begin
      unique case (item.opcode)
        OP_NEXT: begin
          if (cur.alarm) begin
            nxt.sel = (cur.sel == SEL_HOUR) ? SEL_MINUTE : SEL_HOUR;
          end else begin
            nxt.sel = (cur.sel >= SEL_MINUTE) ? SEL_YEAR : cur.sel + 3'd1;
          end
        end
        OP_INC, OP_DEC: begin
          unique case (cur.sel)
            SEL_YEAR: begin
              if (item.opcode == OP_INC) begin
                nxt.year = (cur.year >= YEAR_MAX) ? 7'd0 : cur.year + 7'd1;
              end else begin
                nxt.year = (cur.year == 7'd0) ? YEAR_MAX : cur.year - 7'd1;
              end
              n_days = month_days(nxt.month, nxt.year);
              if (cur.day >= n_days) begin
                nxt.day = n_days - 5'd1;
              end
            end
            SEL_MONTH: begin
              if (item.opcode == OP_INC) begin
                nxt.month = (cur.month >= MONTH_MAX) ? 4'd0 : cur.month + 4'd1;
              end else begin
                nxt.month = (cur.month == 4'd0) ? MONTH_MAX : cur.month - 4'd1;
              end
              n_days = month_days(nxt.month, nxt.year);
              if (cur.day >= n_days) begin
                nxt.day = n_days - 5'd1;
              end
            end
            SEL_DAY: begin
              if (item.opcode == OP_INC) begin
                nxt.day = (({1'b0, cur.day} + 6'd1) >= {1'b0, n_cur}) ? 5'd0 : cur.day + 5'd1;
              end else begin
                nxt.day = (cur.day == 5'd0) ? (n_cur - 5'd1) : cur.day - 5'd1;
              end
            end
            SEL_HOUR: begin
              if (item.opcode == OP_INC) begin
                nxt.hour = (cur.hour >= HOUR_MAX) ? 5'd0 : cur.hour + 5'd1;
              end else begin
                nxt.hour = (cur.hour == 5'd0) ? HOUR_MAX : cur.hour - 5'd1;
              end
            end
            SEL_MINUTE: begin
              if (item.opcode == OP_INC) begin
                nxt.minute = (cur.minute >= MINUTE_MAX) ? 6'd0 : cur.minute + 6'd1;
              end else begin
                nxt.minute = (cur.minute == 6'd0) ? MINUTE_MAX : cur.minute - 6'd1;
              end
            end
            default: begin
            end
          endcase
        end
        OP_CONFIRM: begin
          commit = 1'b1;
          nxt.editing = 1'b0;
        end
        OP_CANCEL: begin
          nxt.editing = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/calendar_time_field_editor_unit.sv =====
// ----------------------------------------------------------------------------
// calendar_time_field_editor_unit
// Key-driven date/time editor with clock and alarm modes.
//
//   channel | dir | beat
//   req     | in  | opcode plus load values
//   rsp     | out | editor fields after the event, commit strobe
//
// Each beat is latched in an input register, applied to the editor state and
// written to the result register: one beat per cycle sustained while rsp.ready
// stays high. The input register advances whenever the result register is
// empty or being taken. Reset (rst, synchronous) clears the state to hour
// selected, not editing, and empties both registers.
// ----------------------------------------------------------------------------
module calendar_time_field_editor_unit import cteu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  cteu_req_if.sink   req,
  cteu_rsp_if.source rsp
);

  logic   s1_valid;
  req_t   s1_item;
  logic   out_valid;
  logic   s1_fire;
  state_t st;
  state_t st_next;
  logic   commit;

  assign s1_fire   = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || s1_fire;
  assign rsp.valid = out_valid;

  cteu_step u_step (
    .cur    (st),
    .item   (s1_item),
    .nxt    (st_next),
    .commit (commit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_item <= req.payload;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      st <= '{year: 7'd0, month: 4'd0, day: 5'd0, hour: 5'd0, minute: 6'd0,
              sel: SEL_HOUR, editing: 1'b0, alarm: 1'b0};
    end else begin
      out_valid <= s1_fire || (out_valid && !rsp.ready);
      if (s1_fire) begin
        st <= st_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      rsp.payload <= '{cur_year: st_next.year, cur_month: st_next.month,
                       cur_day: st_next.day, cur_hour: st_next.hour,
                       cur_minute: st_next.minute, selected_field: st_next.sel,
                       editing: st_next.editing, commit_strobe: commit,
                       alarm_active: st_next.alarm};
    end
  end

`ifndef SYNTHESIS
  a_commit_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && rsp.payload.commit_strobe |-> !rsp.payload.editing)
    else $error("commit beat still editing");

  a_alarm_sel: assert property (@(posedge clk) disable iff (rst)
    st.alarm |-> (st.sel == SEL_HOUR || st.sel == SEL_MINUTE))
    else $error("alarm session selects a date field");

  a_day_range: assert property (@(posedge clk) disable iff (rst)
    st.day < month_days(st.month, st.year))
    else $error("day beyond month length");

  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> s1_valid)
    else $error("accepted beat lost");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !s1_fire |=> $stable(st))
    else $error("state changed without a beat");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the date/time field editor against a cycle-free predictor. A short
// directed table covers saturation, wrap, clamping, alarm mode and ignored
// keys; random edit sessions follow under four idle/stall phases. Every
// result beat is compared field by field with the oldest expected view.
// ----------------------------------------------------------------------------
module testbench;
  import cteu_pkg::*;

  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;
  localparam rsp_t NO_VIEW = '0;

  typedef struct {
    req_t ev;
    bit   typed;
    rsp_t view;
  } key_row_t;

  logic clk;
  logic rst;

  cteu_req_if req_ch ();
  cteu_rsp_if rsp_ch ();

  calendar_time_field_editor_unit DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  state_t   shadow;
  rsp_t     expected_views[$];
  key_row_t key_rows[$];
  int       fail_count = 0;
  int       keys_counted = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [4:0] month_length(logic [3:0] month, logic [6:0] year);
    case (month)
      MONTH_FEB: return (year % 4 == 0) ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10: return 5'd30;
      default: return 5'd31;
    endcase
  endfunction

  function automatic void clamp_day();
    logic [4:0] ndays;
    ndays = month_length(shadow.month, shadow.year);
    if (shadow.day >= ndays) shadow.day = ndays - 5'd1;
  endfunction

  function automatic void step_selected(bit up);
    logic [4:0] ndays;
    case (shadow.sel)
      SEL_YEAR: begin
        if (up) shadow.year = (shadow.year >= YEAR_MAX) ? 7'd0 : shadow.year + 7'd1;
        else shadow.year = (shadow.year == 7'd0) ? YEAR_MAX : shadow.year - 7'd1;
        clamp_day();
      end
      SEL_MONTH: begin
        if (up) shadow.month = (shadow.month >= MONTH_MAX) ? 4'd0 : shadow.month + 4'd1;
        else shadow.month = (shadow.month == 4'd0) ? MONTH_MAX : shadow.month - 4'd1;
        clamp_day();
      end
      SEL_DAY: begin
        ndays = month_length(shadow.month, shadow.year);
        if (up) shadow.day = (shadow.day + 5'd1 >= ndays) ? 5'd0 : shadow.day + 5'd1;
        else shadow.day = (shadow.day == 5'd0) ? ndays - 5'd1 : shadow.day - 5'd1;
      end
      SEL_HOUR: begin
        if (up) shadow.hour = (shadow.hour >= HOUR_MAX) ? 5'd0 : shadow.hour + 5'd1;
        else shadow.hour = (shadow.hour == 5'd0) ? HOUR_MAX : shadow.hour - 5'd1;
      end
      SEL_MINUTE: begin
        if (up) shadow.minute = (shadow.minute >= MINUTE_MAX) ? 6'd0 : shadow.minute + 6'd1;
        else shadow.minute = (shadow.minute == 6'd0) ? MINUTE_MAX : shadow.minute - 6'd1;
      end
      default: ;
    endcase
  endfunction

  function automatic rsp_t apply_key_event(req_t ev);
    rsp_t v;
    logic commit;
    commit = 1'b0;
    if (ev.opcode == OP_LOAD) begin
      shadow.year   = (ev.load_year > YEAR_MAX) ? YEAR_MAX : ev.load_year;
      shadow.month  = (ev.load_month > MONTH_MAX) ? MONTH_MAX : ev.load_month;
      shadow.day    = ev.load_day;
      clamp_day();
      shadow.hour   = (ev.load_hour > HOUR_MAX) ? HOUR_MAX : ev.load_hour;
      shadow.minute = (ev.load_minute > MINUTE_MAX) ? MINUTE_MAX : ev.load_minute;
      shadow.alarm  = ev.load_alarm;
      shadow.sel    = SEL_HOUR;
      shadow.editing = 1'b1;
    end else if (shadow.editing) begin
      case (ev.opcode)
        OP_NEXT: begin
          if (shadow.alarm) shadow.sel = (shadow.sel == SEL_HOUR) ? SEL_MINUTE : SEL_HOUR;
          else shadow.sel = (shadow.sel >= SEL_MINUTE) ? SEL_YEAR : shadow.sel + 3'd1;
        end
        OP_INC: step_selected(1'b1);
        OP_DEC: step_selected(1'b0);
        OP_CONFIRM: begin
          commit = 1'b1;
          shadow.editing = 1'b0;
        end
        OP_CANCEL: shadow.editing = 1'b0;
        default: ;
      endcase
    end
    v.cur_year       = shadow.year;
    v.cur_month      = shadow.month;
    v.cur_day        = shadow.day;
    v.cur_hour       = shadow.hour;
    v.cur_minute     = shadow.minute;
    v.selected_field = shadow.sel;
    v.editing        = shadow.editing;
    v.commit_strobe  = commit;
    v.alarm_active   = shadow.alarm;
    return v;
  endfunction

  function automatic req_t mk_event(logic [2:0] op, logic [6:0] y, logic [3:0] m,
                                    logic [4:0] d, logic [4:0] h, logic [5:0] mi,
                                    logic a);
    return '{op, y, m, d, h, mi, a};
  endfunction

  function automatic rsp_t mk_view(logic [6:0] y, logic [3:0] m, logic [4:0] d,
                                   logic [4:0] h, logic [5:0] mi, logic [2:0] sel,
                                   logic ed, logic cs, logic al);
    return '{y, m, d, h, mi, sel, ed, cs, al};
  endfunction

  function automatic req_t random_key(logic [2:0] op);
    req_t ev;
    ev = req_t'(31'($urandom));
    ev.opcode = op;
    return ev;
  endfunction

  function automatic req_t random_load();
    req_t ev;
    ev = random_key(OP_LOAD);
    if ($urandom_range(99) < 70) begin
      ev.load_year   = 7'($urandom_range(0, 99));
      ev.load_month  = 4'($urandom_range(0, 11));
      ev.load_day    = 5'($urandom_range(0, 30));
      ev.load_hour   = 5'($urandom_range(0, 23));
      ev.load_minute = 6'($urandom_range(0, 59));
    end
    return ev;
  endfunction

  function automatic string view_text(rsp_t v);
    return $sformatf("y=%0d mo=%0d d=%0d h=%0d mi=%0d sel=%0d edit=%0b commit=%0b alarm=%0b",
                     v.cur_year, v.cur_month, v.cur_day, v.cur_hour, v.cur_minute,
                     v.selected_field, v.editing, v.commit_strobe, v.alarm_active);
  endfunction

  function automatic void record_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  function automatic void check_view(rsp_t got);
    rsp_t want;
    if (expected_views.size() == 0) begin
      record_failure({"unexpected beat: ", view_text(got)});
      return;
    end
    want = expected_views.pop_front();
    if (got.cur_year !== want.cur_year || got.cur_month !== want.cur_month ||
        got.cur_day !== want.cur_day || got.cur_hour !== want.cur_hour ||
        got.cur_minute !== want.cur_minute ||
        got.selected_field !== want.selected_field ||
        got.editing !== want.editing || got.commit_strobe !== want.commit_strobe ||
        got.alarm_active !== want.alarm_active)
      record_failure({"mismatch: exp ", view_text(want), " got ", view_text(got)});
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) check_view(rsp_ch.payload);
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_key(input req_t ev, input bit typed, input rsp_t view);
    rsp_t predicted;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.payload <= ev;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (ev.opcode == OP_LOAD || (shadow.editing && ev.opcode <= OP_CANCEL)) keys_counted++;
    predicted = apply_key_event(ev);
    expected_views.push_back(typed ? view : predicted);
  endtask

  task automatic run_session();
    req_t ev;
    int   r;
    send_key(random_load(), 1'b0, NO_VIEW);
    repeat ($urandom_range(1, 16)) begin
      r = $urandom_range(99);
      if (r < 30) ev = random_key(OP_NEXT);
      else if (r < 65) ev = random_key(OP_INC);
      else if (r < 95) ev = random_key(OP_DEC);
      else if (r < 97) ev = random_load();
      else ev = random_key(r[0] ? OP_SPARE7 : OP_SPARE6);
      send_key(ev, 1'b0, NO_VIEW);
    end
    r = $urandom_range(99);
    if (r < 45) send_key(random_key(OP_CONFIRM), 1'b0, NO_VIEW);
    else if (r < 85) send_key(random_key(OP_CANCEL), 1'b0, NO_VIEW);
    repeat ($urandom_range(0, 2)) send_key(random_key(3'($urandom_range(1, 7))), 1'b0, NO_VIEW);
  endtask

  initial begin
    int idle_tab[4];
    int stall_tab[4];
    idle_tab  = '{0, 55, 0, 35};
    stall_tab = '{0, 0, 55, 35};
    rst = 1'b1;
    req_ch.valid   = 1'b0;
    req_ch.payload = '0;
    shadow = '0;
    shadow.sel = SEL_HOUR;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    key_rows.push_back('{mk_event(OP_INC, 127, 15, 31, 31, 63, 1), 1'b1,
                         mk_view(0, 0, 0, 0, 0, SEL_HOUR, 0, 0, 0)});
    key_rows.push_back('{mk_event(OP_SPARE6, 127, 15, 31, 31, 63, 1), 1'b1,
                         mk_view(0, 0, 0, 0, 0, SEL_HOUR, 0, 0, 0)});
    key_rows.push_back('{mk_event(OP_SPARE7, 0, 0, 0, 0, 0, 0), 1'b1,
                         mk_view(0, 0, 0, 0, 0, SEL_HOUR, 0, 0, 0)});
    key_rows.push_back('{mk_event(OP_LOAD, 127, 15, 31, 31, 63, 0), 1'b1,
                         mk_view(99, 11, 30, 23, 59, SEL_HOUR, 1, 0, 0)});
    key_rows.push_back('{mk_event(OP_INC, 0, 0, 0, 0, 0, 0), 1'b1,
                         mk_view(99, 11, 30, 0, 59, SEL_HOUR, 1, 0, 0)});
    key_rows.push_back('{mk_event(OP_NEXT, 0, 0, 0, 0, 0, 0), 1'b0, NO_VIEW});
    key_rows.push_back('{mk_event(OP_INC, 0, 0, 0, 0, 0, 0), 1'b0, NO_VIEW});
    key_rows.push_back('{mk_event(OP_DEC, 0, 0, 0, 0, 0, 0), 1'b0, NO_VIEW});
    key_rows.push_back('{mk_event(OP_NEXT, 0, 0, 0, 0, 0, 0), 1'b0, NO_VIEW});
    key_rows.push_back('{mk_event(OP_INC, 0, 0, 0, 0, 0, 0), 1'b0, NO_VIEW});
    key_rows.push_back('{mk_event(OP_DEC, 0, 0, 0, 0, 0, 0), 1'b0, NO_VIEW});
    key_rows.push_back('{mk_event(OP_NEXT, 0, 0, 0, 0, 0, 0), 1'b0, NO_VIEW});
    key_rows.push_back('{mk_event(OP_INC, 0, 0, 0, 0, 0, 0), 1'b0, NO_VIEW});
    key_rows.push_back('{mk_event(OP_INC, 0, 0, 0, 0, 0, 0), 1'b0, NO_VIEW});
    key_rows.push_back('{mk_event(OP_NEXT, 0, 0, 0, 0, 0, 0), 1'b0, NO_VIEW});
    key_rows.push_back('{mk_event(OP_INC, 0, 0, 0, 0, 0, 0), 1'b0, NO_VIEW});
    key_rows.push_back('{mk_event(OP_DEC, 0, 0, 0, 0, 0, 0), 1'b0, NO_VIEW});
    key_rows.push_back('{mk_event(OP_SPARE6, 0, 0, 0, 0, 0, 0), 1'b0, NO_VIEW});
    key_rows.push_back('{mk_event(OP_CONFIRM, 0, 0, 0, 0, 0, 0), 1'b0, NO_VIEW});
    key_rows.push_back('{mk_event(OP_DEC, 0, 0, 0, 0, 0, 0), 1'b0, NO_VIEW});
    key_rows.push_back('{mk_event(OP_LOAD, 0, 1, 31, 0, 0, 1), 1'b0, NO_VIEW});
    key_rows.push_back('{mk_event(OP_DEC, 0, 0, 0, 0, 0, 0), 1'b0, NO_VIEW});
    key_rows.push_back('{mk_event(OP_NEXT, 0, 0, 0, 0, 0, 0), 1'b0, NO_VIEW});
    key_rows.push_back('{mk_event(OP_NEXT, 0, 0, 0, 0, 0, 0), 1'b0, NO_VIEW});
    key_rows.push_back('{mk_event(OP_LOAD, 5, 3, 31, 12, 30, 0), 1'b0, NO_VIEW});
    key_rows.push_back('{mk_event(OP_CANCEL, 0, 0, 0, 0, 0, 0), 1'b0, NO_VIEW});

    foreach (key_rows[i]) send_key(key_rows[i].ev, key_rows[i].typed, key_rows[i].view);

    keys_counted = 0;
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = idle_tab[phase];
      recv_stall_pct = stall_tab[phase];
      while (keys_counted < 200 * (phase + 1)) run_session();
    end

    req_ch.valid <= 1'b0;
    while (expected_views.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
